// ===== rtl/core/merkle_branch_double_sha256_top_defines.svh =====
// Assertion helpers for the Merkle branch block.
`ifndef MERKLE_BRANCH_DOUBLE_SHA256_TOP_DEFINES_SVH
`define MERKLE_BRANCH_DOUBLE_SHA256_TOP_DEFINES_SVH

// Implication checked on every edge outside reset.
`define MB_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication checked on every edge outside reset.
`define MB_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ===== rtl/core/mbds_pkg.sv =====
`default_nettype none
package mbds_pkg;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_SIB  = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    localparam logic [7:0] SIDE_MASK  = 8'hff;
    localparam logic [7:0] SIDE_RIGHT = 8'd0;
    localparam logic [7:0] SIDE_LEFT  = 8'd1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/merkle_branch_double_sha256_top.sv =====
// Merkle branch folder with double SHA-256, one request at a time.
// Input channel (in_valid/in_stall): op 0 loads start digest word word_index,
// op 1 stores sibling word word_index; sibling word 3 also starts a level whose
// side comes from position (0 sibling right, 1 sibling left, other: set sticky
// error, digest kept). op 2 returns four results on the output channel
// (out_valid/out_stall): digest_word, out_index 0..3, last on the fourth,
// status = error seen; the error is then cleared. op 3 is dropped.
// Load and sibling words 0..2 are stored without stalling the input. A level
// runs one shared round unit: three compressions, each a load step, 64 rounds
// and an add step, with in_stall high meanwhile. An end request holds the
// input until the fourth result is taken, output stalls included; each word
// holds steady while out_stall is high.
// Reset clears the digest to zero, the error flag and the sequencer; sibling
// words are undefined until written.
`default_nettype none
`include "merkle_branch_double_sha256_top_defines.svh"
module merkle_branch_double_sha256_top
    import mbds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [63:0] word,
    input  wire logic [1:0]  word_index,
    input  wire logic [7:0]  position,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      digest_word,
    output logic [1:0]       out_index,
    output logic             last,
    output logic             status
);

    state_t      state_reg, state_next;
    logic [63:0] dig_reg [4];
    logic [63:0] sib_reg [4];
    logic        bad_reg;
    logic [31:0] h_reg [8];     // chain value
    logic [31:0] v_reg [8];     // working a..h
    logic [31:0] w_reg [16];    // message schedule window
    logic [5:0]  rnd_reg;
    logic [1:0]  pass_reg;      // compression 0,1,2
    logic        left_reg;      // sibling first
    logic [1:0]  oidx_reg;

    logic accept;
    logic [31:0] t1, t2, s0, s1, wnew;
    logic [511:0] blk;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (state_reg == ST_OUT);
    assign digest_word = dig_reg[oidx_reg];
    assign out_index = oidx_reg;
    assign last      = (oidx_reg == 2'd3);
    assign status    = bad_reg;

    // Round function: one SHA-256 round plus one schedule word per cycle.
    always_comb
    begin
        t1 = v_reg[7] + (ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[rnd_reg] + w_reg[0];
        t2 = (ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        s0 = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
    end

    // Message block for the current pass, word 0 in the top bits.
    always_comb
    begin
        case (pass_reg)
            2'd0:
            begin
                if (left_reg)
                    blk = {sib_reg[0], sib_reg[1], sib_reg[2], sib_reg[3],
                           dig_reg[0], dig_reg[1], dig_reg[2], dig_reg[3]};
                else
                    blk = {dig_reg[0], dig_reg[1], dig_reg[2], dig_reg[3],
                           sib_reg[0], sib_reg[1], sib_reg[2], sib_reg[3]};
            end
            2'd1: blk = {32'h80000000, 448'd0, 32'd512};
            default:
                blk = {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4], h_reg[5],
                       h_reg[6], h_reg[7], 32'h80000000, 192'd0, 32'd256};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && op == OP_SIB && word_index == 2'd3 &&
                    ((position & SIDE_MASK) == SIDE_RIGHT || (position & SIDE_MASK) == SIDE_LEFT))
                    state_next = ST_START;
                else if (accept && op == OP_END)
                    state_next = ST_OUT;
            end
            ST_START: state_next = ST_ROUND;
            ST_ROUND: if (rnd_reg == 6'd63) state_next = ST_ADD;
            ST_ADD:   state_next = (pass_reg == 2'd2) ? ST_IDLE : ST_START;
            ST_OUT:   if (!out_stall && oidx_reg == 2'd3) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bad_reg   <= 1'b0;
            pass_reg  <= 2'd0;
            oidx_reg  <= 2'd0;
            rnd_reg   <= 6'd0;
            left_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
                dig_reg[i] <= 64'd0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= SHA_IV[i];
                v_reg[i] <= 32'd0;
            end
            for (int i = 0; i < 16; i++)
                w_reg[i] <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && op == OP_LOAD)
                        dig_reg[word_index] <= word;
                    if (accept && op == OP_SIB && word_index == 2'd3)
                    begin
                        if ((position & SIDE_MASK) != SIDE_RIGHT &&
                            (position & SIDE_MASK) != SIDE_LEFT)
                            bad_reg <= 1'b1;
                        left_reg <= ((position & SIDE_MASK) == SIDE_LEFT);
                    end
                    pass_reg <= 2'd0;
                    oidx_reg <= 2'd0;
                end
                ST_START:
                begin
                    // Load chain (IV on passes 0 and 2) and block.
                    for (int i = 0; i < 8; i++)
                    begin
                        if (pass_reg != 2'd1)
                        begin
                            h_reg[i] <= SHA_IV[i];
                            v_reg[i] <= SHA_IV[i];
                        end
                        else
                            v_reg[i] <= h_reg[i];
                    end
                    for (int i = 0; i < 16; i++)
                        w_reg[i] <= blk[511 - 32*i -: 32];
                    rnd_reg <= 6'd0;
                end
                ST_ROUND:
                begin
                    v_reg[0] <= t1 + t2;
                    v_reg[1] <= v_reg[0];
                    v_reg[2] <= v_reg[1];
                    v_reg[3] <= v_reg[2];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[5] <= v_reg[4];
                    v_reg[6] <= v_reg[5];
                    v_reg[7] <= v_reg[6];
                    for (int i = 0; i < 15; i++)
                        w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= wnew;
                    rnd_reg <= rnd_reg + 6'd1;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    if (pass_reg == 2'd2)
                        for (int i = 0; i < 4; i++)
                            dig_reg[i] <= {h_reg[2*i] + v_reg[2*i], h_reg[2*i+1] + v_reg[2*i+1]};
                    pass_reg <= pass_reg + 2'd1;
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        oidx_reg <= oidx_reg + 2'd1;
                        if (oidx_reg == 2'd3)
                            bad_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Sibling store: written on any accepted sibling word.
    always_ff @(posedge clk)
    begin
        if (accept && op == OP_SIB)
            sib_reg[word_index] <= word;
    end

    `MB_ASSERT_IMPL(a_out_idle_in, clk, rst_n, out_valid, in_stall, "output while input open")
    `MB_ASSERT_NEXT(a_last_done, clk, rst_n, out_valid && last && !out_stall, !out_valid,
        "output beyond last word")
    `MB_ASSERT_NEXT(a_err_clear, clk, rst_n, out_valid && last && !out_stall, !status,
        "error flag not cleared after end")

endmodule
`default_nettype wire
